FILE: src/hpq_pkg.sv
// ----------------------------------------------------------------------------
// hpq_pkg
// Shared types, codes and the control store of the heap sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package hpq_pkg;

    localparam int KEY_W = 32;
    localparam int CNT_W = 7;

    localparam logic [CNT_W-1:0] CAP_RESET = 7'd64;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    // Program steps; the step counter walks them in this order unless a jump is taken.
    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_INS_CHECK,
        S_UP_READ,
        S_UP_MOVE,
        S_INS_WRITE,
        S_REM_CHECK,
        S_REM_LAST,
        S_REM_SETUP,
        S_DN_LEFT,
        S_DN_RIGHT,
        S_DN_PICK,
        S_DN_MOVE,
        S_REM_WRITE,
        S_FINISH
    } step_t;

    typedef enum logic [3:0] {
        A_LATCH,
        A_NOP,
        A_INS_BEGIN,
        A_RD_PARENT,
        A_UP_MOVE,
        A_WR_KEY,
        A_REM_BEGIN,
        A_RD_LAST,
        A_REM_SETUP,
        A_RD_LEFT,
        A_TAKE_LEFT,
        A_TAKE_RIGHT,
        A_DN_MOVE,
        A_FINISH
    } act_t;

    typedef enum logic [3:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_START,
        C_OP_REM,
        C_FULL,
        C_AT_ROOT,
        C_PARENT_LESS,
        C_EMPTY,
        C_NO_CHILD,
        C_NO_RIGHT,
        C_CHILD_GREATER
    } cond_t;

    typedef struct packed {
        act_t  act;
        cond_t cond;
        step_t target;
    } ctrl_t;

    // Control store: one word per step. When the condition holds the counter
    // loads the target, otherwise it advances by one.
    function automatic ctrl_t hpq_rom(step_t s);
        ctrl_t w;
        unique case (s)
            S_IDLE:      w = '{A_LATCH,      C_NO_START,      S_IDLE};
            S_DISPATCH:  w = '{A_NOP,        C_OP_REM,        S_REM_CHECK};
            S_INS_CHECK: w = '{A_INS_BEGIN,  C_FULL,          S_FINISH};
            S_UP_READ:   w = '{A_RD_PARENT,  C_AT_ROOT,       S_INS_WRITE};
            S_UP_MOVE:   w = '{A_UP_MOVE,    C_PARENT_LESS,   S_UP_READ};
            S_INS_WRITE: w = '{A_WR_KEY,     C_ALWAYS,        S_FINISH};
            S_REM_CHECK: w = '{A_REM_BEGIN,  C_EMPTY,         S_FINISH};
            S_REM_LAST:  w = '{A_RD_LAST,    C_NEVER,         S_IDLE};
            S_REM_SETUP: w = '{A_REM_SETUP,  C_NEVER,         S_IDLE};
            S_DN_LEFT:   w = '{A_RD_LEFT,    C_NO_CHILD,      S_REM_WRITE};
            S_DN_RIGHT:  w = '{A_TAKE_LEFT,  C_NO_RIGHT,      S_DN_MOVE};
            S_DN_PICK:   w = '{A_TAKE_RIGHT, C_NEVER,         S_IDLE};
            S_DN_MOVE:   w = '{A_DN_MOVE,    C_CHILD_GREATER, S_DN_LEFT};
            S_REM_WRITE: w = '{A_WR_KEY,     C_NEVER,         S_IDLE};
            S_FINISH:    w = '{A_FINISH,     C_ALWAYS,        S_IDLE};
            default:     w = '{A_NOP,        C_ALWAYS,        S_IDLE};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

FILE: src/hpq_ram.sv
// ----------------------------------------------------------------------------
// hpq_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module hpq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  wire logic                       clk,
    input  wire logic                       we,
    input  wire logic [$clog2(DEPTH)-1:0]   waddr,
    input  wire logic [WIDTH-1:0]           wdata,
    input  wire logic [$clog2(DEPTH)-1:0]   raddr,
    output logic      [WIDTH-1:0]           rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

FILE: src/max_heap_priority_queue.sv
// ----------------------------------------------------------------------------
// max_heap_priority_queue
// Binary max-heap of signed 32-bit keys, run by a microcoded sequencer.
// ----------------------------------------------------------------------------
//  Channel    Signals                          Direction  Beat
//  command    start, operation, key            in         start & !busy
//  result     done, top_value, status,         out        done (one cycle)
//             count_after
//  config     cfg_write, cfg_data (capacity)   in         cfg_write
//
// The heap lives in one RAM with a single read port; every level of a sift going
// up reads the parent and then moves it, and every level going down reads the left
// child, reads the right child, picks the larger and moves it, skipping the pick
// when the node has no right child.
// Reset clears the count and restores capacity to 64; the store needs no clear.
// done is high for exactly one cycle and cannot be stalled; busy is low again
// in that cycle, so the next command may be taken alongside the result.
// ----------------------------------------------------------------------------
`default_nettype none

module max_heap_priority_queue #(
    parameter int DEPTH = 64
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic               operation,
    input  wire logic signed [31:0] key,
    output logic                    done,
    output logic signed [31:0]      top_value,
    output logic [1:0]              status,
    output logic [6:0]              count_after,
    input  wire logic               cfg_write,
    input  wire logic [6:0]         cfg_data
);

    localparam int AW        = $clog2(DEPTH + 1);
    localparam int RAM_DEPTH = 2 ** AW;
    localparam int CMPW      = (AW + 1 > hpq_pkg::CNT_W) ? AW + 1 : hpq_pkg::CNT_W;

    hpq_pkg::step_t              step_reg, step_next;
    hpq_pkg::status_t            status_reg, status_next;
    logic                        op_reg, op_next;
    logic signed [31:0]          key_reg, key_next;
    logic signed [31:0]          top_reg, top_next;
    logic signed [31:0]          bval_reg, bval_next;
    logic [AW-1:0]               pos_reg, pos_next;
    logic [AW-1:0]               best_reg, best_next;
    logic [hpq_pkg::CNT_W-1:0]   count_reg, count_next;
    logic [hpq_pkg::CNT_W-1:0]   capacity_reg;
    logic                        done_reg, done_next;

    hpq_pkg::ctrl_t              ctrl;
    logic                        jump;
    logic [AW:0]                 child_l;
    logic [AW:0]                 child_r;
    logic                        full;
    logic                        empty;
    logic                        at_root;
    logic                        parent_less;
    logic                        no_child;
    logic                        no_right;
    logic                        child_greater;

    logic                        ram_we;
    logic [AW-1:0]               ram_raddr;
    logic [31:0]                 ram_wdata;
    logic [31:0]                 ram_rdata;

    hpq_ram #(
        .WIDTH (32),
        .DEPTH (RAM_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (pos_reg),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign ctrl    = hpq_pkg::hpq_rom(step_reg);
    assign child_l = {pos_reg, 1'b0};
    assign child_r = {pos_reg, 1'b1};

    // Capacity above the store depth saturates at the depth.
    assign full = (CMPW'(count_reg) >= CMPW'(capacity_reg)) ||
                  (CMPW'(count_reg) >= CMPW'(DEPTH));
    assign empty         = (count_reg == '0);
    assign at_root       = (pos_reg == AW'(1));
    assign parent_less   = ($signed(ram_rdata) < key_reg);
    assign no_child      = (CMPW'(child_l) > CMPW'(count_reg));
    assign no_right      = (CMPW'(child_r) > CMPW'(count_reg));
    assign child_greater = (key_reg < bval_reg);

    always_comb
    begin
        unique case (ctrl.cond)
            hpq_pkg::C_NEVER:         jump = 1'b0;
            hpq_pkg::C_ALWAYS:        jump = 1'b1;
            hpq_pkg::C_NO_START:      jump = !start;
            hpq_pkg::C_OP_REM:        jump = op_reg;
            hpq_pkg::C_FULL:          jump = full;
            hpq_pkg::C_AT_ROOT:       jump = at_root;
            hpq_pkg::C_PARENT_LESS:   jump = parent_less;
            hpq_pkg::C_EMPTY:         jump = empty;
            hpq_pkg::C_NO_CHILD:      jump = no_child;
            hpq_pkg::C_NO_RIGHT:      jump = no_right;
            hpq_pkg::C_CHILD_GREATER: jump = child_greater;
            default:                  jump = 1'b0;
        endcase
    end

    always_comb
    begin
        step_next   = jump ? ctrl.target : hpq_pkg::step_t'(step_reg + 4'd1);
        status_next = status_reg;
        op_next     = op_reg;
        key_next    = key_reg;
        top_next    = top_reg;
        bval_next   = bval_reg;
        pos_next    = pos_reg;
        best_next   = best_reg;
        count_next  = count_reg;
        done_next   = 1'b0;
        ram_we      = 1'b0;
        ram_raddr   = pos_reg;
        ram_wdata   = key_reg;

        unique case (ctrl.act)
            hpq_pkg::A_LATCH:
            begin
                if (start)
                begin
                    op_next  = operation;
                    key_next = key;
                end
            end
            hpq_pkg::A_NOP:
            begin
            end
            hpq_pkg::A_INS_BEGIN:
            begin
                top_next = '0;
                if (full)
                begin
                    status_next = hpq_pkg::ST_FULL;
                end
                else
                begin
                    status_next = hpq_pkg::ST_DONE;
                    count_next  = count_reg + 1'b1;
                    pos_next    = AW'(count_reg) + AW'(1);
                end
            end
            hpq_pkg::A_RD_PARENT:
            begin
                ram_raddr = pos_reg >> 1;
            end
            hpq_pkg::A_UP_MOVE:
            begin
                // A smaller parent slides down into the hole.
                if (parent_less)
                begin
                    ram_we    = 1'b1;
                    ram_wdata = ram_rdata;
                    pos_next  = pos_reg >> 1;
                end
            end
            hpq_pkg::A_WR_KEY:
            begin
                ram_we    = 1'b1;
                ram_wdata = key_reg;
            end
            hpq_pkg::A_REM_BEGIN:
            begin
                ram_raddr = AW'(1);
                if (empty)
                begin
                    top_next    = '1;
                    status_next = hpq_pkg::ST_EMPTY;
                end
                else
                begin
                    status_next = hpq_pkg::ST_DONE;
                end
            end
            hpq_pkg::A_RD_LAST:
            begin
                top_next  = ram_rdata;
                ram_raddr = AW'(count_reg);
            end
            hpq_pkg::A_REM_SETUP:
            begin
                // The last entry becomes the key that sifts down from the root.
                key_next   = ram_rdata;
                count_next = count_reg - 1'b1;
                pos_next   = AW'(1);
            end
            hpq_pkg::A_RD_LEFT:
            begin
                ram_raddr = child_l[AW-1:0];
            end
            hpq_pkg::A_TAKE_LEFT:
            begin
                best_next = child_l[AW-1:0];
                bval_next = ram_rdata;
                ram_raddr = child_r[AW-1:0];
            end
            hpq_pkg::A_TAKE_RIGHT:
            begin
                // The right child wins only when strictly larger.
                if ($signed(ram_rdata) > bval_reg)
                begin
                    best_next = child_r[AW-1:0];
                    bval_next = ram_rdata;
                end
            end
            hpq_pkg::A_DN_MOVE:
            begin
                if (child_greater)
                begin
                    ram_we    = 1'b1;
                    ram_wdata = bval_reg;
                    pos_next  = best_reg;
                end
            end
            hpq_pkg::A_FINISH:
            begin
                done_next = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg     <= hpq_pkg::S_IDLE;
            count_reg    <= '0;
            done_reg     <= 1'b0;
            capacity_reg <= hpq_pkg::CAP_RESET;
        end
        else
        begin
            step_reg  <= step_next;
            count_reg <= count_next;
            done_reg  <= done_next;
            if (cfg_write)
            begin
                capacity_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        op_reg     <= op_next;
        key_reg    <= key_next;
        top_reg    <= top_next;
        bval_reg   <= bval_next;
        pos_reg    <= pos_next;
        best_reg   <= best_next;
    end

    assign busy        = (step_reg != hpq_pkg::S_IDLE);
    assign done        = done_reg;
    assign top_value   = top_reg;
    assign status      = status_reg;
    assign count_after = count_reg;

    // A result beat only follows the finishing step of the program.
    a_done_after_finish: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(step_reg == hpq_pkg::S_FINISH))
        else $error("result beat without finishing step");

    // An accepted command keeps the sequencer busy on the next cycle.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("command accepted but sequencer not busy");

    // The store is written only while a command is in progress.
    a_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> busy)
        else $error("store write while idle");

    // The entry count never passes the store depth.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        CMPW'(count_reg) <= CMPW'(DEPTH))
        else $error("entry count beyond depth");

    // A refused insert leaves the count where it was.
    a_full_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status_reg == hpq_pkg::ST_FULL) |-> $stable(count_reg))
        else $error("refused insert changed the count");

endmodule

`default_nettype wire

FILE: test/max_heap_priority_queue_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// max_heap_priority_queue_tb
// Drives insert and remove-top commands into the heap and checks every result
// beat against a behavioral heap kept inside the testbench. Directed tests
// cover empty and full heaps, extreme keys, ties and capacity changes. Random
// phases then fill and drain the heap under several capacities.
// ----------------------------------------------------------------------------
module max_heap_priority_queue_tb;

    localparam int HEAP_DEPTH = 64;
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;
    localparam logic signed [31:0] KEY_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] KEY_MIN = 32'sh8000_0000;

    typedef struct {
        logic signed [31:0] top_value;
        hpq_pkg::status_t   status;
        logic [6:0]         count_after;
    } heap_outcome_t;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic               operation;
    logic signed [31:0] key;
    logic               done;
    logic signed [31:0] top_value;
    logic [1:0]         status;
    logic [6:0]         count_after;
    logic               cfg_write;
    logic [6:0]         cfg_data;

    logic signed [31:0] shadow_heap [1:HEAP_DEPTH];
    int                 shadow_count;
    int                 shadow_capacity;
    heap_outcome_t      outcome_q [$];
    int                 error_count;
    bit                 idle_enabled;

    max_heap_priority_queue #(
        .DEPTH(HEAP_DEPTH)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .operation(operation),
        .key(key),
        .done(done),
        .top_value(top_value),
        .status(status),
        .count_after(count_after),
        .cfg_write(cfg_write),
        .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        $display("ERROR at %0t: %s", $time, msg);
        error_count++;
    endtask

    // Applies one command to the shadow heap and returns the result it must give.
    function automatic heap_outcome_t heap_apply(input logic op, input logic signed [31:0] k);
        heap_outcome_t      o;
        int                 lim;
        int                 pos;
        int                 parent;
        int                 child;
        int                 best;
        bit                 settled;
        logic signed [31:0] last;
        o.top_value = '0;
        o.status = hpq_pkg::ST_DONE;
        lim = (shadow_capacity > HEAP_DEPTH) ? HEAP_DEPTH : shadow_capacity;
        if (op == OP_INSERT)
        begin
            if (shadow_count + 1 > lim)
                o.status = hpq_pkg::ST_FULL;
            else
            begin
                shadow_count++;
                pos = shadow_count;
                parent = pos / 2;
                while (parent >= 1 && shadow_heap[parent] < k)
                begin
                    shadow_heap[pos] = shadow_heap[parent];
                    pos = parent;
                    parent = pos / 2;
                end
                shadow_heap[pos] = k;
            end
        end
        else if (shadow_count == 0)
        begin
            o.top_value = -32'sd1;
            o.status = hpq_pkg::ST_EMPTY;
        end
        else
        begin
            o.top_value = shadow_heap[1];
            last = shadow_heap[shadow_count];
            shadow_count--;
            pos = 1;
            settled = 1'b0;
            while (!settled)
            begin
                child = 2 * pos;
                if (child > shadow_count)
                    settled = 1'b1;
                else
                begin
                    best = child;
                    if (child + 1 <= shadow_count && shadow_heap[child + 1] > shadow_heap[child])
                        best = child + 1;
                    if (last < shadow_heap[best])
                    begin
                        shadow_heap[pos] = shadow_heap[best];
                        pos = best;
                    end
                    else
                        settled = 1'b1;
                end
            end
            shadow_heap[pos] = last;
        end
        o.count_after = shadow_count[6:0];
        return o;
    endfunction

    // Keys lean on the extremes and on a narrow band so that ties are common.
    function automatic logic signed [31:0] pick_key();
        logic signed [31:0] r;
        case ($urandom_range(0, 9))
            0: r = KEY_MAX;
            1: r = KEY_MIN;
            2, 3: r = $signed(32'($urandom_range(0, 6))) - 32'sd3;
            default: r = $urandom;
        endcase
        return r;
    endfunction

    // Called on a clock edge; returns on the edge that accepted the beat, with
    // start still high so a following command can go out back to back.
    task automatic send_command(input logic op, input logic signed [31:0] k);
        start <= 1'b1;
        operation <= op;
        key <= k;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        outcome_q.push_back(heap_apply(op, k));
    endtask

    task automatic maybe_idle();
        if (idle_enabled && $urandom_range(0, 3) == 0)
        begin
            start <= 1'b0;
            operation <= 1'($urandom);
            key <= $urandom;
            repeat ($urandom_range(1, 15))
                @(posedge clk);
        end
    endtask

    task automatic quiesce();
        start <= 1'b0;
        while (outcome_q.size() != 0)
            @(posedge clk);
        repeat (4)
            @(posedge clk);
    endtask

    task automatic set_capacity(input logic [6:0] value);
        quiesce();
        cfg_write <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        cfg_write <= 1'b0;
        shadow_capacity = value;
    endtask

    always @(posedge clk)
    begin : result_check
        heap_outcome_t oldest;
        if (rst_n && done)
        begin
            if (outcome_q.size() == 0)
                report_mismatch("result beat with no command pending");
            else
            begin
                oldest = outcome_q.pop_front();
                if (top_value !== oldest.top_value)
                    report_mismatch($sformatf("top_value %0d, expected %0d",
                                              top_value, oldest.top_value));
                if (status !== oldest.status)
                    report_mismatch($sformatf("status %0d, expected %0d",
                                              status, oldest.status));
                if (count_after !== oldest.count_after)
                    report_mismatch($sformatf("count_after %0d, expected %0d",
                                              count_after, oldest.count_after));
            end
        end
    end

    task automatic test_empty_and_extremes();
        send_command(OP_REMOVE, KEY_MAX);
        send_command(OP_INSERT, KEY_MIN);
        send_command(OP_INSERT, KEY_MAX);
        send_command(OP_INSERT, 32'sd0);
        maybe_idle();
        send_command(OP_INSERT, -32'sd1);
        send_command(OP_INSERT, 32'sd1);
        repeat (6)
            send_command(OP_REMOVE, $urandom);
    endtask

    // Equal children exercise the left-first rule during sift-down.
    task automatic test_ties();
        send_command(OP_INSERT, 32'sd5);
        send_command(OP_INSERT, 32'sd5);
        send_command(OP_INSERT, 32'sd7);
        send_command(OP_INSERT, 32'sd5);
        send_command(OP_INSERT, 32'sd7);
        send_command(OP_INSERT, 32'sd3);
        repeat (6)
            send_command(OP_REMOVE, 32'sd0);
    endtask

    task automatic test_capacity_limits();
        set_capacity(7'd0);
        send_command(OP_INSERT, 32'sd9);
        send_command(OP_REMOVE, 32'sd0);
        set_capacity(7'd2);
        repeat (3)
            send_command(OP_INSERT, pick_key());
        set_capacity(7'd64);
        repeat (4)
            send_command(OP_INSERT, pick_key());
        // Capacity now sits below the count: inserts must fail, removes still work.
        set_capacity(7'd3);
        send_command(OP_INSERT, 32'sd1);
        repeat (3)
            send_command(OP_REMOVE, 32'sd0);
        send_command(OP_INSERT, 32'sd2);
        send_command(OP_REMOVE, 32'sd0);
        send_command(OP_INSERT, 32'sd2);
    endtask

    // Alternates filling runs up to the limit with draining runs down to empty.
    task automatic test_random_phase(input logic [6:0] cap, input int beats);
        bit filling;
        int lim;
        set_capacity(cap);
        lim = (shadow_capacity > HEAP_DEPTH) ? HEAP_DEPTH : shadow_capacity;
        filling = (shadow_count < lim);
        repeat (beats)
        begin
            if (filling && shadow_count >= lim && $urandom_range(0, 3) == 0)
                filling = 1'b0;
            else if (!filling && shadow_count == 0 && $urandom_range(0, 3) == 0)
                filling = 1'b1;
            if ($urandom_range(0, 9) == 0)
                send_command(1'($urandom), pick_key());
            else if (filling)
                send_command(($urandom_range(0, 9) == 0) ? OP_REMOVE : OP_INSERT, pick_key());
            else
                send_command(($urandom_range(0, 9) < 2) ? OP_INSERT : OP_REMOVE, pick_key());
            maybe_idle();
        end
    endtask

    initial
    begin
        error_count = 0;
        shadow_count = 0;
        shadow_capacity = 64;
        idle_enabled = 1'b1;
        rst_n = 1'b0;
        start <= 1'b0;
        operation <= OP_INSERT;
        key <= '0;
        cfg_write <= 1'b0;
        cfg_data <= '0;
        repeat (5)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_and_extremes();
        test_ties();
        test_capacity_limits();
        test_random_phase(7'd127, 140);
        test_random_phase(7'd16, 130);
        test_random_phase(7'd1, 100);
        test_random_phase(7'd64, 140);
        test_random_phase(7'($urandom_range(2, 63)), 120);
        test_random_phase(7'd0, 20);
        idle_enabled = 1'b0;
        test_random_phase(7'd127, 140);

        start <= 1'b0;
        while (outcome_q.size() != 0)
            @(posedge clk);
        repeat (40)
            @(posedge clk);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

FILE: max_heap_priority_queue.f
src/hpq_pkg.sv
src/hpq_ram.sv
src/max_heap_priority_queue.sv
test/max_heap_priority_queue_tb.sv
